// ===== design/ddod_pkg.sv =====
// ----------------------------------------------------------------------------
// ddod_pkg
// Shared widths, register indexes, pipeline payload types and the
// arctangent table for the differential-drive odometry delta block.
// ----------------------------------------------------------------------------
package ddod_pkg;

    // port widths
    localparam int CNT_IN_W  = 16;
    localparam int DIST_W    = 24;
    localparam int BASE_W    = 32;
    localparam int FWD_W     = 40;
    localparam int TURN_W    = 18;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // parameter defaults
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int ATAN_ENTRIES     = 24;

    // internal widths
    localparam int CNT_W   = DIST_W + 1;          // sign-extended count
    localparam int PROD_W  = 2 * CNT_W;           // wheel distance
    localparam int DIFF_W  = PROD_W + 1;          // sum and difference
    localparam int NORM_W  = 64;                  // normalization word
    localparam int CORD_W  = 33;                  // cordic x, y and angle
    localparam int ANG_W   = 30;                  // normalized magnitude bits
    localparam int RND_SH  = 14;                  // Q2.30 to Q2.16
    localparam int RND_W   = CORD_W - RND_SH;     // rounded angle width

    localparam logic [TURN_W-1:0] HALF_PI_Q16 = TURN_W'(102944);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b1;

    localparam logic [DIST_W-1:0] DIST_RST = DIST_W'(65536);
    localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(6553600);

    // payload through the normalization cells
    typedef struct packed {
        logic signed [FWD_W-1:0] fwd;
        logic                    neg;
        logic                    zero;
        logic [NORM_W-1:0]       ay;
        logic [NORM_W-1:0]       bx;
    } t_norm;

    // payload through the cordic cells
    typedef struct packed {
        logic signed [FWD_W-1:0]  fwd;
        logic                     neg;
        logic                     zero;
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic signed [CORD_W-1:0] z;
    } t_cord;

    // atan(2^-i) in Q2.30 radians
    function automatic logic [CORD_W-1:0] atan_q30(input int unsigned idx);
        logic [CORD_W-1:0] v;
        case (idx)
            0:       v = CORD_W'(32'h3243F6A8);
            1:       v = CORD_W'(32'h1DAC6705);
            2:       v = CORD_W'(32'h0FADBAFC);
            3:       v = CORD_W'(32'h07F56EA6);
            4:       v = CORD_W'(32'h03FEAB76);
            5:       v = CORD_W'(32'h01FFD55B);
            6:       v = CORD_W'(32'h00FFFAAA);
            7:       v = CORD_W'(32'h007FFF55);
            8:       v = CORD_W'(32'h003FFFEA);
            9:       v = CORD_W'(32'h001FFFFD);
            10:      v = CORD_W'(32'h000FFFFF);
            11:      v = CORD_W'(32'h0007FFFF);
            12:      v = CORD_W'(32'h0003FFFF);
            13:      v = CORD_W'(32'h0001FFFF);
            14:      v = CORD_W'(32'h0000FFFF);
            15:      v = CORD_W'(32'h00007FFF);
            16:      v = CORD_W'(32'h00003FFF);
            17:      v = CORD_W'(32'h00001FFF);
            18:      v = CORD_W'(32'h00000FFF);
            19:      v = CORD_W'(32'h000007FF);
            20:      v = CORD_W'(32'h000003FF);
            21:      v = CORD_W'(32'h000001FF);
            22:      v = CORD_W'(32'h000000FF);
            23:      v = CORD_W'(32'h0000007F);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ddod_front.sv =====
// ----------------------------------------------------------------------------
// ddod_front
// Input register, wheel distance multipliers, forward mean with saturation,
// and magnitude of the wheel distance difference: four pipeline stages.
// ----------------------------------------------------------------------------
module ddod_front #(
    parameter int COUNT_WIDTH = ddod_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ddod_pkg::CNT_IN_W-1:0] i_left_count,
    input  logic signed [ddod_pkg::CNT_IN_W-1:0] i_right_count,
    input  logic [ddod_pkg::DIST_W-1:0]          i_dist,
    input  logic [ddod_pkg::BASE_W-1:0]          i_base,
    output logic                                o_valid,
    input  logic                                i_ready,
    output ddod_pkg::t_norm                      o_data
);
    import ddod_pkg::*;

    localparam int PAD = CNT_W - COUNT_WIDTH;

    logic                     r_v1, r_v2, r_v3, r_v4;
    logic                     rdy1, rdy2, rdy3, rdy4;
    logic signed [CNT_W-1:0]  r_lc, r_rc, n_lc, n_rc;
    logic signed [PROD_W-1:0] r_dl, r_dr, n_dl, n_dr;
    logic signed [FWD_W-1:0]  r_fwd, n_fwd;
    logic signed [DIFF_W-1:0] r_y, n_y;
    logic signed [FWD_W-1:0]  r_fwd4;
    t_norm                    r_out, n_out;
    logic [CNT_W-1:0]         l_wide, r_wide;
    logic [COUNT_WIDTH-1:0]   l_raw, r_raw;
    logic signed [CNT_W-1:0]  dist_s;
    logic signed [DIFF_W-1:0] sum, half;
    logic [DIFF_W-1:0]        ay;

    // stall chain from the output side
    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;
    assign o_data  = r_out;

    // take the low count bits as two's complement
    assign l_wide = {{(CNT_W-CNT_IN_W){1'b0}}, i_left_count};
    assign r_wide = {{(CNT_W-CNT_IN_W){1'b0}}, i_right_count};
    assign l_raw  = l_wide[COUNT_WIDTH-1:0];
    assign r_raw  = r_wide[COUNT_WIDTH-1:0];
    assign n_lc   = {{PAD{l_raw[COUNT_WIDTH-1]}}, l_raw};
    assign n_rc   = {{PAD{r_raw[COUNT_WIDTH-1]}}, r_raw};

    // wheel distances
    assign dist_s = {1'b0, i_dist};
    assign n_dl   = r_lc * dist_s;
    assign n_dr   = r_rc * dist_s;

    // forward mean, floor halving, saturate to the output range
    assign sum  = {r_dl[PROD_W-1], r_dl} + {r_dr[PROD_W-1], r_dr};
    assign half = sum >>> 1;
    always_comb begin
        if (half[DIFF_W-1:FWD_W-1] == '0 || half[DIFF_W-1:FWD_W-1] == '1) begin
            n_fwd = half[FWD_W-1:0];
        end else if (half[DIFF_W-1]) begin
            n_fwd = {1'b1, {(FWD_W-1){1'b0}}};
        end else begin
            n_fwd = {1'b0, {(FWD_W-1){1'b1}}};
        end
    end
    assign n_y = {r_dr[PROD_W-1], r_dr} - {r_dl[PROD_W-1], r_dl};

    // sign and magnitude of the difference
    assign ay = r_y[DIFF_W-1] ? DIFF_W'(-r_y) : DIFF_W'(r_y);
    always_comb begin
        n_out.fwd  = r_fwd4;
        n_out.neg  = r_y[DIFF_W-1];
        n_out.zero = (r_y == '0);
        n_out.ay   = {{(NORM_W-DIFF_W){1'b0}}, ay};
        n_out.bx   = {{(NORM_W-BASE_W){1'b0}}, i_base};
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_lc <= n_lc;
            r_rc <= n_rc;
        end
        if (rdy2 && r_v1) begin
            r_dl <= n_dl;
            r_dr <= n_dr;
        end
        if (rdy3 && r_v2) begin
            r_fwd <= n_fwd;
            r_y   <= n_y;
        end
        if (rdy4 && r_v3) begin
            r_out <= n_out;
        end
    end

    assign r_fwd4 = r_fwd;

endmodule

// ===== design/ddod_norm_cell.sv =====
// ----------------------------------------------------------------------------
// ddod_norm_cell
// One step of the binary normalization: shifts both magnitudes left by a
// fixed amount when the top bits of their union are all clear.
// ----------------------------------------------------------------------------
module ddod_norm_cell #(
    parameter int SHIFT = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ddod_pkg::t_norm i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output ddod_pkg::t_norm o_data
);
    import ddod_pkg::*;

    logic              r_valid;
    t_norm             r_data, n_data;
    logic [NORM_W-1:0] both;
    logic              top_clear;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // conditional left shift
    assign both      = i_data.ay | i_data.bx;
    assign top_clear = (both[NORM_W-1 -: SHIFT] == '0);
    always_comb begin
        n_data = i_data;
        if (top_clear) begin
            n_data.ay = i_data.ay << SHIFT;
            n_data.bx = i_data.bx << SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/ddod_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ddod_cordic_cell
// One vectoring iteration of the cordic: rotates toward the x axis by
// atan(2^-IDX) and accumulates the angle.
// ----------------------------------------------------------------------------
module ddod_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ddod_pkg::t_cord i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output ddod_pkg::t_cord o_data
);
    import ddod_pkg::*;

    localparam logic signed [CORD_W-1:0] ATAN = atan_q30(IDX);

    logic                     r_valid;
    t_cord                    r_data, n_data;
    logic signed [CORD_W-1:0] dx, dy;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // micro-rotation
    assign dx = i_data.cx >>> IDX;
    assign dy = i_data.cy >>> IDX;
    always_comb begin
        n_data = i_data;
        if (!i_data.cy[CORD_W-1]) begin
            n_data.cx = i_data.cx + dy;
            n_data.cy = i_data.cy - dx;
            n_data.z  = i_data.z + ATAN;
        end else begin
            n_data.cx = i_data.cx - dy;
            n_data.cy = i_data.cy + dx;
            n_data.z  = i_data.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/diff_drive_odometry_delta.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_delta
// Per-tick odometry delta of a differential-drive base: forward distance
// and heading change from the two wheel encoder counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries the left and right encoder
//   counts of one tick; output channel (o_valid / i_ready) returns the
//   forward distance (Q24.16 mm) and turn (Q2.16 rad) for that tick.
//   Distance per count and wheel base are set through the write port
//   (i_cfg_we, i_cfg_idx, i_cfg_wdata) while no transaction is in flight.
//   The pipeline is four front stages, six normalization stages, one
//   cordic cell per iteration and the rounding/output stage. Every stage
//   is a register with its own valid bit, so one transaction is accepted
//   per cycle while the receiver keeps up, and several are in flight.
//   When the receiver stalls, results collect in the empty stages and
//   o_ready drops only once every stage holds a transaction.
//   Reset clears all stage valid bits and loads the registers with a
//   distance per count of 1.0 mm and a wheel base of 100.0 mm.
// ----------------------------------------------------------------------------
module diff_drive_odometry_delta #(
    parameter int CORDIC_STEPS = ddod_pkg::CORDIC_STEPS_DEF,
    parameter int COUNT_WIDTH  = ddod_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ddod_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ddod_pkg::CFG_DAT_W-1:0]        i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [ddod_pkg::CNT_IN_W-1:0]  i_left_count,
    input  logic signed [ddod_pkg::CNT_IN_W-1:0]  i_right_count,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ddod_pkg::FWD_W-1:0]     o_forward_mm,
    output logic signed [ddod_pkg::TURN_W-1:0]    o_turn_rad
);
    import ddod_pkg::*;

    localparam int NSTEP  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int NNORM  = 6;

    logic [DIST_W-1:0] r_dist;
    logic [BASE_W-1:0] r_base;

    t_norm norm_d [NNORM+1];
    logic  norm_v [NNORM+1];
    logic  norm_r [NNORM+1];
    t_cord cord_d [NSTEP+1];
    logic  cord_v [NSTEP+1];
    logic  cord_r [NSTEP+1];

    logic                     r_valid;
    logic signed [FWD_W-1:0]  r_fwd;
    logic signed [TURN_W-1:0] r_turn, n_turn;
    logic                     out_rdy;
    logic signed [CORD_W-1:0] zr;
    logic signed [RND_W-1:0]  rq;
    logic [TURN_W-1:0]        mag;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= DIST_RST;
            r_base <= BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIST: r_dist <= i_cfg_wdata[DIST_W-1:0];
                CFG_BASE: r_base <= i_cfg_wdata[BASE_W-1:0];
                default:  ;
            endcase
        end
    end

    // front stages
    ddod_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_left_count  (i_left_count),
        .i_right_count (i_right_count),
        .i_dist        (r_dist),
        .i_base        (r_base),
        .o_valid       (norm_v[0]),
        .i_ready       (norm_r[0]),
        .o_data        (norm_d[0])
    );

    // normalization chain: shifts of 32, 16, 8, 4, 2, 1
    for (genvar k = 0; k < NNORM; k++) begin : g_norm
        ddod_norm_cell #(
            .SHIFT (32 >> k)
        ) u_norm (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (norm_v[k]),
            .o_ready (norm_r[k]),
            .i_data  (norm_d[k]),
            .o_valid (norm_v[k+1]),
            .i_ready (norm_r[k+1]),
            .o_data  (norm_d[k+1])
        );
    end

    // leading one now at the top bit: keep the upper magnitude bits
    assign cord_v[0]    = norm_v[NNORM];
    assign norm_r[NNORM] = cord_r[0];
    always_comb begin
        cord_d[0].fwd  = norm_d[NNORM].fwd;
        cord_d[0].neg  = norm_d[NNORM].neg;
        cord_d[0].zero = norm_d[NNORM].zero;
        cord_d[0].cx   = {{(CORD_W-ANG_W){1'b0}}, norm_d[NNORM].bx[NORM_W-1 -: ANG_W]};
        cord_d[0].cy   = {{(CORD_W-ANG_W){1'b0}}, norm_d[NNORM].ay[NORM_W-1 -: ANG_W]};
        cord_d[0].z    = '0;
    end

    // cordic chain
    for (genvar k = 0; k < NSTEP; k++) begin : g_cord
        ddod_cordic_cell #(
            .IDX (k)
        ) u_cord (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cord_v[k]),
            .o_ready (cord_r[k]),
            .i_data  (cord_d[k]),
            .o_valid (cord_v[k+1]),
            .i_ready (cord_r[k+1]),
            .o_data  (cord_d[k+1])
        );
    end

    // round to Q2.16, clamp to [0, pi/2], apply sign
    assign zr  = cord_d[NSTEP].z + CORD_W'(1 << (RND_SH - 1));
    assign rq  = zr[CORD_W-1:RND_SH];
    always_comb begin
        if (rq[RND_W-1]) begin
            mag = '0;
        end else if (rq > $signed({1'b0, HALF_PI_Q16})) begin
            mag = HALF_PI_Q16;
        end else begin
            mag = rq[TURN_W-1:0];
        end
        if (cord_d[NSTEP].zero) begin
            n_turn = '0;
        end else if (cord_d[NSTEP].neg) begin
            n_turn = -$signed(mag);
        end else begin
            n_turn = $signed(mag);
        end
    end

    // output register
    assign out_rdy       = !r_valid || i_ready;
    assign cord_r[NSTEP] = out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_rdy) begin
            r_valid <= cord_v[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && cord_v[NSTEP]) begin
            r_fwd  <= cord_d[NSTEP].fwd;
            r_turn <= n_turn;
        end
    end

    assign o_valid      = r_valid;
    assign o_forward_mm = r_fwd;
    assign o_turn_rad   = r_turn;

endmodule

// ===== design/ddod_check.sv =====
// ----------------------------------------------------------------------------
// ddod_check
// Port-level checks on the odometry delta block, bound to the top level.
// ----------------------------------------------------------------------------
module ddod_check (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic signed [ddod_pkg::FWD_W-1:0]     o_forward_mm,
    input logic signed [ddod_pkg::TURN_W-1:0]    o_turn_rad
);
    import ddod_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_forward_mm) && $stable(o_turn_rad))
        else $error("stalled result changed");

    // turn stays within plus or minus pi/2
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_turn_rad <= $signed({1'b0, HALF_PI_Q16}))
                 && (o_turn_rad >= -$signed({1'b0, HALF_PI_Q16})))
        else $error("turn out of range");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // an empty output stage never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

endmodule

bind diff_drive_odometry_delta ddod_check u_ddod_check (.*);
